// ----- rtl/core/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, constants and the divider step for the world-to-screen
// projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package wsp_pkg;

	localparam int BITS_PER_STEP = 2;
	localparam int QUO_W         = 32;
	localparam int DIV_STEPS     = QUO_W / BITS_PER_STEP;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	typedef enum logic [2:0] {
		REG_ROW0     = 3'd0,
		REG_ROW1     = 3'd1,
		REG_ROW2     = 3'd2,
		REG_ROW3     = 3'd3,
		REG_VIEWPORT = 3'd4,
		REG_VIEW_OK  = 3'd5
	} cfg_idx_t;

	typedef logic [3:0][63:0] matrix_t;

	typedef struct packed {
		logic valid;
		logic op;
		logic rej;
	} ctl_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
	} div_pair_t;

	// One pipeline step of restoring division. The remaining dividend bits
	// shift out of the top of num while quotient bits shift into its bottom.
	function automatic div_pair_t div_step(logic [31:0] rem, logic [31:0] num,
		logic [31:0] den);
		div_pair_t  res;
		logic [32:0] t;
		logic [31:0] r;
		logic [31:0] n;
		r = rem;
		n = num;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			t = {r, n[31]};
			n = {n[30:0], 1'b0};
			if (t >= {1'b0, den}) begin
				t    = t - {1'b0, den};
				n[0] = 1'b1;
			end
			r = t[31:0];
		end
		res.rem = r;
		res.num = n;
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wsp_mac.sv -----
// ----------------------------------------------------------------------------
// wsp_mac
// Matrix multiply of the homogeneous point: one stage of products, one stage
// of column sums with flooring to Q16.16 and an overflow check.
// ----------------------------------------------------------------------------
`default_nettype none
module wsp_mac import wsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire ctl_t               ctl_in,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire logic signed [31:0] pz,
	input  wire matrix_t            mat,
	output ctl_t                    ctl_out,
	output logic signed [31:0]      clip [4]
);

	ctl_t                ctl_s1;
	ctl_t                ctl_s2;
	logic signed [47:0]  prod_s1 [3][4];
	logic signed [31:0]  clip_s2 [4];
	logic signed [50:0]  acc [4];
	logic signed [40:0]  acc_sh [4];
	logic [3:0]          ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= '{valid: ctl_s1.valid, op: ctl_s1.op, rej: ctl_s1.rej | (|ovf)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				prod_s1[0][j] <= px * $signed(mat[0][16*j +: 16]);
				prod_s1[1][j] <= py * $signed(mat[1][16*j +: 16]);
				prod_s1[2][j] <= pz * $signed(mat[2][16*j +: 16]);
				clip_s2[j]    <= acc_sh[j][31:0];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			acc[j] = 51'(prod_s1[0][j]) + 51'(prod_s1[1][j]) + 51'(prod_s1[2][j])
				+ 51'($signed({mat[3][16*j +: 16], 16'b0}));
			acc_sh[j] = 41'(acc[j] >>> 10);
			ovf[j] = (acc_sh[j][40:31] != {10{acc_sh[j][31]}});
		end
	end

	assign ctl_out = ctl_s2;
	assign clip    = clip_s2;

endmodule
`default_nettype wire

// ----- rtl/core/wsp_div.sv -----
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider for three lanes: (clip << 16) / w, truncated
// toward zero, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wsp_div import wsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire ctl_t               ctl_in,
	input  wire logic signed [31:0] clip [4],
	output ctl_t                    ctl_out,
	output logic [31:0]             mag [3],
	output logic [2:0]              neg
);

	ctl_t        ctl_s [DIV_STEPS+1];
	logic [31:0] rem_s [DIV_STEPS+1][3];
	logic [31:0] num_s [DIV_STEPS+1][3];
	logic [31:0] den_s [DIV_STEPS+1];
	logic [2:0]  neg_s [DIV_STEPS+1];
	logic [31:0] in_mag [3];
	logic [2:0]  pre_ovf;
	logic        w_bad;

	always_comb begin
		w_bad = (clip[3] <= 32'sd1);
		for (int l = 0; l < 3; l++) begin
			in_mag[l]  = clip[l][31] ? 32'(-clip[l]) : 32'(clip[l]);
			pre_ovf[l] = ({16'b0, in_mag[l][31:16]} >= 32'(clip[3]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) ctl_s[k] <= '0;
		end else if (en) begin
			ctl_s[0] <= '{valid: ctl_in.valid, op: ctl_in.op,
				rej: ctl_in.rej | w_bad | (|pre_ovf)};
			for (int k = 1; k <= DIV_STEPS; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= 32'(clip[3]);
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= {16'b0, in_mag[l][31:16]};
				num_s[0][l] <= {in_mag[l][15:0], 16'b0};
				neg_s[0][l] <= clip[l][31];
			end
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		div_pair_t nxt [3];
		always_comb begin
			for (int l = 0; l < 3; l++)
				nxt[l] = div_step(rem_s[k-1][l], num_s[k-1][l], den_s[k-1]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				for (int l = 0; l < 3; l++) begin
					rem_s[k][l] <= nxt[l].rem;
					num_s[k][l] <= nxt[l].num;
				end
			end
		end
	end

	assign ctl_out = ctl_s[DIV_STEPS];
	assign mag     = num_s[DIV_STEPS];
	assign neg     = neg_s[DIV_STEPS];

endmodule
`default_nettype wire

// ----- rtl/core/wsp_map.sv -----
// ----------------------------------------------------------------------------
// wsp_map
// Range tests and clamping of the normalized point, then the viewport
// mapping with y flipped and saturation. The last stage is the output word.
// ----------------------------------------------------------------------------
`default_nettype none
module wsp_map import wsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire ctl_t               ctl_in,
	input  wire logic [31:0]        mag [3],
	input  wire logic [2:0]         neg,
	input  wire logic [63:0]        vp,
	input  wire logic               view_ok,
	output logic                    out_valid,
	output logic                    visible,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y,
	output logic                    clamped
);

	ctl_t               ctl_s1;
	ctl_t               ctl_s2;
	logic               valid_s3;
	logic [17:0]        ux_s1;
	logic [17:0]        uy_s1;
	logic               flag_s1;
	logic               flag_s2;
	logic [33:0]        px_s2;
	logic [33:0]        py_s2;
	logic               vis_s3;
	logic signed [31:0] sx_s3;
	logic signed [31:0] sy_s3;
	logic               clamp_s3;

	logic signed [32:0] v [3];
	logic signed [31:0] ndc [3];
	logic [2:0]         ovf;
	logic               z_bad;
	logic               x_out;
	logic               y_out;
	logic signed [31:0] cx;
	logic signed [31:0] cy;
	logic signed [32:0] ux;
	logic signed [32:0] uy;
	logic               rej;
	logic               flag;
	logic signed [35:0] sx;
	logic signed [35:0] sy;
	logic               vis;

	function automatic logic signed [31:0] sat32(logic signed [35:0] a);
		if (a[35:31] == {5{a[31]}}) return a[31:0];
		return a[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	function automatic logic signed [31:0] clamp_unit(logic signed [31:0] a);
		if (a < -ONE_Q16) return -ONE_Q16;
		if (a > ONE_Q16) return ONE_Q16;
		return a;
	endfunction

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			v[l]   = neg[l] ? -$signed({1'b0, mag[l]}) : $signed({1'b0, mag[l]});
			ovf[l] = (v[l][32] != v[l][31]);
			ndc[l] = v[l][31:0];
		end
		z_bad = (ndc[2] < 32'sd0) || (ndc[2] > ONE_Q16);
		x_out = (ndc[0] < -ONE_Q16) || (ndc[0] > ONE_Q16);
		y_out = (ndc[1] < -ONE_Q16) || (ndc[1] > ONE_Q16);
		cx    = clamp_unit(ndc[0]);
		cy    = clamp_unit(ndc[1]);
		rej   = ctl_in.rej | (|ovf) | z_bad | (!ctl_in.op & (x_out | y_out));
		flag  = ctl_in.op & (x_out | y_out);
		ux    = 33'(cx) + 33'(ONE_Q16);
		uy    = 33'(ONE_Q16) - 33'(cy);
		sx    = 36'($signed({vp[15:0], 16'b0})) + $signed({3'b0, px_s2[33:1]});
		sy    = 36'($signed({vp[31:16], 16'b0})) + $signed({3'b0, py_s2[33:1]});
		vis   = !ctl_s2.rej & view_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			ctl_s1   <= '{valid: ctl_in.valid, op: ctl_in.op, rej: rej};
			ctl_s2   <= ctl_s1;
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1    <= ux[17:0];
			uy_s1    <= uy[17:0];
			flag_s1  <= flag;
			px_s2    <= ux_s1 * vp[47:32];
			py_s2    <= uy_s1 * vp[63:48];
			flag_s2  <= flag_s1;
			vis_s3   <= vis;
			sx_s3    <= vis ? sat32(sx) : '0;
			sy_s3    <= vis ? sat32(sy) : '0;
			clamp_s3 <= vis & flag_s2;
		end
	end

	assign out_valid = valid_s3;
	assign visible   = vis_s3;
	assign screen_x  = sx_s3;
	assign screen_y  = sy_s3;
	assign clamped   = clamp_s3;

endmodule
`default_nettype wire

// ----- rtl/core/world_to_screen_projection.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of a Q16.16 world point through a 4x4 matrix and a
// viewport transform to Q16.16 screen pixels.
// ----------------------------------------------------------------------------
// The block takes one point per cycle while the output word is taken and
// returns one word per point, in order. A point passes through the matrix
// products and sums, the divider (a setup stage and sixteen stages of two
// quotient bits each), and the range tests, viewport scaling and the output
// register. The whole pipeline holds when the output word is not taken.
// Registers are to be written through the configuration port only while
// no point is in flight; the block itself does not enforce this.
`default_nettype none
module world_to_screen_projection import wsp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic signed [31:0] world_x,
	input  wire logic signed [31:0] world_y,
	input  wire logic signed [31:0] world_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    visible,
	output logic signed [31:0]      screen_x,
	output logic signed [31:0]      screen_y,
	output logic                    clamped
);

	matrix_t            mat_q;
	logic [63:0]        vp_q;
	logic               view_ok_q;
	logic               en;
	ctl_t               ctl_in;
	ctl_t               ctl_mac;
	ctl_t               ctl_div;
	logic signed [31:0] clip [4];
	logic [31:0]        mag [3];
	logic [2:0]         neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q     <= '0;
			vp_q      <= '0;
			view_ok_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW0:     mat_q[0]  <= cfg_data;
				REG_ROW1:     mat_q[1]  <= cfg_data;
				REG_ROW2:     mat_q[2]  <= cfg_data;
				REG_ROW3:     mat_q[3]  <= cfg_data;
				REG_VIEWPORT: vp_q      <= cfg_data;
				REG_VIEW_OK:  view_ok_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_comb begin
		ctl_in.valid = in_valid;
		ctl_in.op    = op;
		ctl_in.rej   = 1'b0;
	end

	wsp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.px      (world_x),
		.py      (world_y),
		.pz      (world_z),
		.mat     (mat_q),
		.ctl_out (ctl_mac),
		.clip    (clip)
	);

	wsp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_mac),
		.clip    (clip),
		.ctl_out (ctl_div),
		.mag     (mag),
		.neg     (neg)
	);

	wsp_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ctl_div),
		.mag       (mag),
		.neg       (neg),
		.vp        (vp_q),
		.view_ok   (view_ok_q),
		.out_valid (out_valid),
		.visible   (visible),
		.screen_x  (screen_x),
		.screen_y  (screen_y),
		.clamped   (clamped)
	);

endmodule
`default_nettype wire
